[hdl/dpw_antialiased_oscillator_core_defines.svh]
// Assertion macros shared by the DPW oscillator core RTL.
`ifndef DPW_ANTIALIASED_OSCILLATOR_CORE_DEFINES_SVH
`define DPW_ANTIALIASED_OSCILLATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define DPW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("DPW oscillator assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define DPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("DPW oscillator assertion failed");
`else
`define DPW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DPW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/dpwosc_pkg.sv]
// Types and constants of the DPW oscillator core.
package dpwosc_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DPW_GAIN   = 2'd2;

   localparam int CSR_DATA_BITS = 40;
   localparam int MODE_BITS     = 3;
   localparam int STEP_BITS     = 32;
   localparam int GAIN_BITS     = 40;

   // Waveform modes.
   localparam logic [MODE_BITS-1:0] MODE_SINE   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_TRI    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_SAW    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_AA_TRI = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_AA_SAW = 3'd4;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 40'd1048576;

   // Quarter-wave table generation: pi/2 in Q2.31 and the Taylor denominators.
   localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
   localparam logic [63:0] DPW_DENOMS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ADDR,
      ST_RDA,
      ST_RDB,
      ST_DIFF,
      ST_INTERP,
      ST_SQUARE,
      ST_DIFFER,
      ST_GHI,
      ST_GLO,
      ST_GSUM,
      ST_FINISH
   } dpw_state_type;

endpackage

[hdl/dpw_antialiased_oscillator_core.sv]
// DPW antialiased oscillator core: one audio sample for every accepted tick transaction.
// Triangle, saw and undefined modes pass from acceptance to the finish state, the
// antialiased modes via square, difference and, unless clipped, gain states, and sine via
// scale, address, ROM read, difference and interpolation; req_ready rises with rsp_valid.
// One 34x32 multiplier and one sine ROM read port are shared; a stalled result adds waits.
// Synchronous active-high reset restores register defaults and clears phase and memory.
`include "dpw_antialiased_oscillator_core_defines.svh"

module dpw_antialiased_oscillator_core #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_BITS      = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_block_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample,
   output logic                                  rsp_sample_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpwosc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dpwosc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import dpwosc_pkg::*;

   localparam int IDX_BITS    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int WIDE        = SAMPLE_BITS + 4;
   localparam int ROM_SHIFT   = 32 - SAMPLE_BITS;
   localparam int ALIAS_SHIFT = 33 - SAMPLE_BITS;
   localparam int TRI_SHIFT   = 52 - SAMPLE_BITS;
   localparam int SAW_SHIFT   = 53 - SAMPLE_BITS;

   localparam logic signed [WIDE-1:0] OUT_MAX_W = WIDE'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [WIDE-1:0] OUT_MIN_W = -OUT_MAX_W - WIDE'(1);
   localparam logic [SAMPLE_BITS:0]   SINE_MAX  = {2'b00, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS+1:0] GAIN_CAP  = {1'b1, {(SAMPLE_BITS + 1){1'b0}}};
   localparam logic signed [35:0]     Q32_ONE   = 36'sh1_0000_0000;

   typedef logic [SAMPLE_BITS-1:0] rom_type [SINE_TABLE_DEPTH+1];

   // Quarter-wave sine table, evaluated at elaboration with the odd polynomial.
   function automatic rom_type build_sine_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x  = (HALF_PI_Q31 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> 31;
         t  = 64'd1 << 31;
         for (int k = 0; k < 6; k++) begin
            t = (64'd1 << 31) - (((x2 * t) >> 31) / DPW_DENOMS[k]);
         end
         s = (x * t) >> 31;
         if (ROM_SHIFT > 0) begin
            s = (s + (64'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
         end
         rom[i] = s[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_sine_rom();

   function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      if (v > OUT_MAX_W) begin
         r = OUT_MAX_W;
      end else if (v < OUT_MIN_W) begin
         r = OUT_MIN_W;
      end else begin
         r = v;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   // Control registers.
   dpw_state_type          state_ff, state_in;
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic signed [33:0]     mem_ff, mem_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [31:0]            p_ff, p_in;
   logic                   last_ff, last_in;
   logic [65:0]            prod_ff, prod_in;
   logic [IDX_BITS-1:0]    rom_addr_ff, rom_addr_in;
   logic [SAMPLE_BITS-1:0] rom_q_ff;
   logic [29:0]            frac_ff, frac_in;
   logic                   at_end_ff, at_end_in;
   logic [SAMPLE_BITS-1:0] sa_ff, sa_in;
   logic [SAMPLE_BITS-1:0] sd_ff, sd_in;
   logic                   sdneg_ff, sdneg_in;
   logic [33:0]            dmag_ff, dmag_in;
   logic                   dneg_ff, dneg_in;
   logic [53:0]            hi_ff, hi_in;
   logic [SAMPLE_BITS+1:0] m_ff, m_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic                   req_accept;
   logic                   csr_write;
   logic                   slot_free;
   logic [31:0]            phase_top;
   logic [PHASE_BITS-1:0]  phase_next;
   logic [31:0]            bm;
   logic [30:0]            sine_pos;
   logic [33:0]            mult_a;
   logic [31:0]            mult_b;
   logic [65:0]            mult_prod;
   logic [IDX_BITS-1:0]    sine_idx;
   logic [32:0]            sq;
   logic signed [34:0]     aa_cur;
   logic signed [34:0]     aa_diff;
   logic [54:0]            gain_sum;
   logic [54:0]            gain_shifted;
   logic [SAMPLE_BITS-1:0] sine_interp;
   logic [SAMPLE_BITS:0]   sine_sum;
   logic [SAMPLE_BITS:0]   sine_clamped;
   logic signed [35:0]     alias_tri;
   logic signed [35:0]     alias_saw;
   logic signed [WIDE-1:0] sine_w;
   logic signed [WIDE-1:0] result_w;

   assign req_accept = req_valid && req_ready;
   assign csr_write  = csr_valid && csr_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   generate
      if (PHASE_BITS >= 32) begin : g_top_wide
         assign phase_top = phase_ff[PHASE_BITS-1 -: 32];
      end else begin : g_top_narrow
         assign phase_top = {phase_ff, {(32 - PHASE_BITS){1'b0}}};
      end
   endgenerate

   assign phase_next = phase_ff + PHASE_BITS'(step_ff);

   // Magnitude of the bipolar phase 2p-1, in units of 2^-31.
   assign bm       = p_ff[31] ? {1'b0, p_ff[30:0]} : (32'h8000_0000 - p_ff);
   // Odd quadrants read the quarter wave backwards.
   assign sine_pos = p_ff[30] ? (31'h4000_0000 - {1'b0, p_ff[29:0]}) : {1'b0, p_ff[29:0]};

   always_comb begin
      mult_a = '0;
      mult_b = '0;
      case (state_ff)
         ST_SCALE: begin
            mult_a = 34'(sine_pos);
            mult_b = 32'(SINE_TABLE_DEPTH);
         end
         ST_INTERP: begin
            mult_a = 34'(sd_ff);
            mult_b = 32'(frac_ff);
         end
         ST_SQUARE: begin
            mult_a = 34'(bm);
            mult_b = bm;
         end
         ST_GHI: begin
            mult_a = dmag_ff;
            mult_b = 32'(gain_ff[39:20]);
         end
         ST_GLO: begin
            mult_a = dmag_ff;
            mult_b = 32'(gain_ff[19:0]);
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign mult_prod = 66'(mult_a) * 66'(mult_b);

   assign sine_idx = prod_ff[30 +: IDX_BITS];

   // Differentiator input: squared bipolar phase, or the signed parabola.
   assign sq = prod_ff[62:30];
   always_comb begin
      if (mode_ff == MODE_AA_TRI) begin
         aa_cur = 35'sh1_0000_0000 - $signed({2'b00, sq});
         if (!p_ff[31]) begin
            aa_cur = -aa_cur;
         end
      end else begin
         aa_cur = $signed({2'b00, sq});
      end
   end
   assign aa_diff = aa_cur - $signed({mem_ff[33], mem_ff});

   assign gain_sum     = 55'({hi_ff[32:0], 20'd0}) + 55'(prod_ff[53:0]);
   assign gain_shifted = (mode_ff == MODE_AA_TRI) ? (gain_sum >> TRI_SHIFT)
                                                  : (gain_sum >> SAW_SHIFT);

   assign sine_interp = prod_ff[30 +: SAMPLE_BITS];
   always_comb begin
      if (at_end_ff) begin
         sine_sum = {1'b0, sa_ff};
      end else if (sdneg_ff) begin
         sine_sum = {1'b0, sa_ff} - {1'b0, sine_interp};
      end else begin
         sine_sum = {1'b0, sa_ff} + {1'b0, sine_interp};
      end
      sine_clamped = (sine_sum > SINE_MAX) ? SINE_MAX : sine_sum;
      sine_w       = $signed({3'b000, sine_clamped});
      if (p_ff[31]) begin
         sine_w = -sine_w;
      end
   end

   assign alias_tri = $signed({2'b00, bm, 2'b00}) - Q32_ONE;
   assign alias_saw = $signed({3'b000, p_ff, 1'b0}) - Q32_ONE;

   always_comb begin
      case (mode_ff)
         MODE_SINE:   result_w = sine_w;
         MODE_TRI:    result_w = WIDE'(alias_tri >>> ALIAS_SHIFT);
         MODE_SAW:    result_w = WIDE'(alias_saw >>> ALIAS_SHIFT);
         MODE_AA_TRI: result_w = (OUT_MAX_W + WIDE'(1)) - $signed({2'b00, m_ff});
         MODE_AA_SAW: result_w = dneg_ff ? -$signed({2'b00, m_ff}) : $signed({2'b00, m_ff});
         default:     result_w = '0;
      endcase
   end

   // Sequencer and next-state values.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      step_in       = step_ff;
      gain_in       = gain_ff;
      phase_in      = phase_ff;
      mem_in        = mem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      p_in          = p_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      rom_addr_in   = rom_addr_ff;
      frac_in       = frac_ff;
      at_end_in     = at_end_ff;
      sa_in         = sa_ff;
      sd_in         = sd_ff;
      sdneg_in      = sdneg_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      hi_in         = hi_ff;
      m_in          = m_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               p_in     = phase_top;
               last_in  = req_block_end;
               phase_in = phase_next;
               unique case (mode_ff) inside
                  MODE_SINE:                state_in = ST_SCALE;
                  MODE_AA_TRI, MODE_AA_SAW: state_in = ST_SQUARE;
                  default:                  state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCALE: begin
            prod_in  = mult_prod;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            rom_addr_in = sine_idx;
            frac_in     = prod_ff[29:0];
            at_end_in   = (sine_idx >= IDX_BITS'(SINE_TABLE_DEPTH));
            state_in    = ST_RDA;
         end
         ST_RDA: begin
            // The end entry is read twice; interpolation is skipped there.
            if (!at_end_ff) begin
               rom_addr_in = rom_addr_ff + 1'b1;
            end
            state_in = ST_RDB;
         end
         ST_RDB: begin
            sa_in    = rom_q_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (rom_q_ff >= sa_ff) begin
               sd_in    = rom_q_ff - sa_ff;
               sdneg_in = 1'b0;
            end else begin
               sd_in    = sa_ff - rom_q_ff;
               sdneg_in = 1'b1;
            end
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            prod_in  = mult_prod;
            state_in = ST_FINISH;
         end
         ST_SQUARE: begin
            prod_in  = mult_prod;
            state_in = ST_DIFFER;
         end
         ST_DIFFER: begin
            mem_in  = aa_cur[33:0];
            dneg_in = aa_diff[34];
            dmag_in = aa_diff[34] ? 34'(-aa_diff) : aa_diff[33:0];
            // A rising parabola clips to zero in the triangle mode.
            if (mode_ff == MODE_AA_TRI && !aa_diff[34]) begin
               m_in     = '0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GHI;
            end
         end
         ST_GHI: begin
            prod_in  = mult_prod;
            state_in = ST_GLO;
         end
         ST_GLO: begin
            hi_in    = prod_ff[53:0];
            prod_in  = mult_prod;
            state_in = ST_GSUM;
         end
         ST_GSUM: begin
            if (hi_ff[53:33] != '0 || gain_shifted > 55'(GAIN_CAP)) begin
               m_in = GAIN_CAP;
            end else begin
               m_in = gain_shifted[SAMPLE_BITS+1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = saturate(result_w);
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A configuration write takes priority; a mode write restarts the waveform.
      if (csr_write) begin
         unique case (csr_index)
            CSR_WAVE_MODE: begin
               mode_in  = csr_wdata[MODE_BITS-1:0];
               phase_in = '0;
               mem_in   = '0;
            end
            CSR_PHASE_STEP: begin
               step_in = csr_wdata[STEP_BITS-1:0];
            end
            CSR_DPW_GAIN: begin
               gain_in = csr_wdata[GAIN_BITS-1:0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SINE;
         step_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         phase_ff     <= '0;
         mem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         gain_ff      <= gain_in;
         phase_ff     <= phase_in;
         mem_ff       <= mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      rom_addr_ff   <= rom_addr_in;
      rom_q_ff      <= SINE_ROM[rom_addr_ff];
      frac_ff       <= frac_in;
      at_end_ff     <= at_end_in;
      sa_ff         <= sa_in;
      sd_ff         <= sd_in;
      sdneg_ff      <= sdneg_in;
      dmag_ff       <= dmag_in;
      dneg_ff       <= dneg_in;
      hi_ff         <= hi_in;
      m_ff          <= m_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_sample_last = rsp_last_ff;

   `DPW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `DPW_ASSERT_NEXT(a_mode_write_clears, clock, reset,
      csr_write && csr_index == CSR_WAVE_MODE,
      phase_ff == '0 && mem_ff == '0)
   `DPW_ASSERT_NEXT(a_finish_delivers, clock, reset,
      state_ff == ST_FINISH && slot_free,
      rsp_valid_ff && state_ff == ST_IDLE)
   `DPW_ASSERT_NEXT(a_phase_advance, clock, reset,
      req_accept && !(csr_valid && csr_index == CSR_WAVE_MODE),
      phase_ff == $past(phase_next))

endmodule
